// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/nts_pkg.sv
package nts_pkg;

   localparam int SINE_ENTRIES         = 64;
   localparam int SINE_IDX_W           = $clog2(SINE_ENTRIES);
   localparam int MAX_STEPS_PER_SAMPLE = 128;
   localparam int STEP_CNT_W           = $clog2(MAX_STEPS_PER_SAMPLE + 1);
   localparam int STEP_REG_W           = 23;
   localparam int PHASE_W              = 32;
   localparam int POS_W                = 16;
   localparam int NOISE_W              = 16;
   localparam int LEVEL_W              = 8;
   localparam int SMOOTH_W             = 24;
   localparam int SUM_W                = 11;
   localparam int SAMPLE_W             = 16;
   localparam int QUEUE_DEPTH          = 4;
   localparam int QUEUE_PTR_W          = $clog2(QUEUE_DEPTH);

   localparam logic [STEP_REG_W-1:0] STEP_RESET_VALUE = 23'd1141307;
   localparam logic [SMOOTH_W-1:0]   SMOOTH_MAX       = 24'hFF0000;
   localparam logic [SAMPLE_W-1:0]   SAMPLE_OFFSET    = 16'h8000;

   typedef enum logic [1:0] {
      REQ_TICK       = 2'd0,
      REQ_CONTROL    = 2'd1,
      REQ_NOISE_CLEAR = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SMOOTH,
      BK_MIX
   } back_state_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]    target;
      logic [STEP_CNT_W-1:0] steps;
      logic [SINE_IDX_W:0]   pos;
      logic                  tone_low;
      logic                  tone_high;
      logic                  explosion;
   } tick_entry_type;

   function automatic logic [LEVEL_W-1:0] wave_lookup(input logic [SINE_IDX_W-1:0] idx);
      logic [LEVEL_W-1:0] val;
      case (idx)
         6'd0:  val = 8'd128;  6'd1:  val = 8'd140;  6'd2:  val = 8'd153;  6'd3:  val = 8'd165;
         6'd4:  val = 8'd177;  6'd5:  val = 8'd188;  6'd6:  val = 8'd199;  6'd7:  val = 8'd209;
         6'd8:  val = 8'd218;  6'd9:  val = 8'd226;  6'd10: val = 8'd234;  6'd11: val = 8'd240;
         6'd12: val = 8'd245;  6'd13: val = 8'd250;  6'd14: val = 8'd253;  6'd15: val = 8'd254;
         6'd16: val = 8'd255;  6'd17: val = 8'd254;  6'd18: val = 8'd253;  6'd19: val = 8'd250;
         6'd20: val = 8'd245;  6'd21: val = 8'd240;  6'd22: val = 8'd234;  6'd23: val = 8'd226;
         6'd24: val = 8'd218;  6'd25: val = 8'd209;  6'd26: val = 8'd199;  6'd27: val = 8'd188;
         6'd28: val = 8'd177;  6'd29: val = 8'd165;  6'd30: val = 8'd153;  6'd31: val = 8'd140;
         6'd32: val = 8'd128;  6'd33: val = 8'd116;  6'd34: val = 8'd103;  6'd35: val = 8'd91;
         6'd36: val = 8'd79;   6'd37: val = 8'd68;   6'd38: val = 8'd57;   6'd39: val = 8'd47;
         6'd40: val = 8'd38;   6'd41: val = 8'd30;   6'd42: val = 8'd22;   6'd43: val = 8'd16;
         6'd44: val = 8'd11;   6'd45: val = 8'd6;    6'd46: val = 8'd3;    6'd47: val = 8'd2;
         6'd48: val = 8'd1;    6'd49: val = 8'd2;    6'd50: val = 8'd3;    6'd51: val = 8'd6;
         6'd52: val = 8'd11;   6'd53: val = 8'd16;   6'd54: val = 8'd22;   6'd55: val = 8'd30;
         6'd56: val = 8'd38;   6'd57: val = 8'd47;   6'd58: val = 8'd57;   6'd59: val = 8'd68;
         6'd60: val = 8'd79;   6'd61: val = 8'd91;   6'd62: val = 8'd103;  6'd63: val = 8'd116;
         default: val = 8'd128;
      endcase
      return val;
   endfunction

   function automatic logic [LEVEL_W-1:0] level_lookup(input logic [2:0] vol);
      logic [LEVEL_W-1:0] val;
      case (vol)
         3'd0:    val = 8'h00;
         3'd1:    val = 8'h20;
         3'd2:    val = 8'h40;
         3'd3:    val = 8'h60;
         3'd4:    val = 8'h80;
         3'd5:    val = 8'hA0;
         3'd6:    val = 8'hC0;
         3'd7:    val = 8'hFF;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

// File: hw/rtl/nts_queue.sv
module nts_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  nts_pkg::tick_entry_type wr_data,
   output logic                    full,
   input  logic                    rd_en,
   output nts_pkg::tick_entry_type rd_data,
   output logic                    empty
);
   import nts_pkg::*;

   tick_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     do_wr, do_rd;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hw/rtl/nts_front.sv
module nts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [1:0]                          kind,
   input  logic [7:0]                          control_byte,
   input  logic                                step_wr,
   input  logic [nts_pkg::STEP_REG_W-1:0]      step_data,
   output logic                                tick_push,
   output nts_pkg::tick_entry_type             tick_entry
);
   import nts_pkg::*;

   logic [STEP_REG_W-1:0] step_ff, step_in;
   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [POS_W-1:0]      last_ff, last_in;
   logic [NOISE_W-1:0]    noise_ff, noise_in;
   logic [LEVEL_W-1:0]    target_ff, target_in;
   logic [2:0]            volume_ff, volume_in;
   logic                  low_ff, low_in;
   logic                  high_ff, high_in;
   logic                  boom_ff, boom_in;

   logic [PHASE_W-1:0]    phase_sum;
   logic [POS_W-1:0]      cur;
   logic [POS_W-1:0]      diff;
   logic                  crossed;
   logic [NOISE_W-1:0]    noise_stepped;
   logic [LEVEL_W-1:0]    target_tick;
   logic [STEP_CNT_W-1:0] steps;

   assign phase_sum     = phase_ff + PHASE_W'(step_ff);
   assign cur           = phase_sum[PHASE_W-1 -: POS_W];
   assign diff          = cur - last_ff;
   assign crossed       = (cur[POS_W-1:6] != last_ff[POS_W-1:6]);
   assign noise_stepped = {noise_ff[NOISE_W-2:0], ~(noise_ff[14] ^ noise_ff[6])};
   assign steps         = (diff > POS_W'(MAX_STEPS_PER_SAMPLE)) ?
                          STEP_CNT_W'(MAX_STEPS_PER_SAMPLE) : diff[STEP_CNT_W-1:0];

   always_comb begin
      target_tick = target_ff;
      if (crossed) begin
         target_tick = noise_stepped[13] ? level_lookup(volume_ff) : '0;
      end
   end

   always_comb begin
      step_in   = step_wr ? step_data : step_ff;
      phase_in  = phase_ff;
      last_in   = last_ff;
      noise_in  = noise_ff;
      target_in = target_ff;
      volume_in = volume_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      boom_in   = boom_ff;
      tick_push = 1'b0;
      if (accept) begin
         case (req_kind_type'(kind))
            REQ_TICK: begin
               phase_in  = phase_sum;
               last_in   = cur;
               target_in = target_tick;
               tick_push = 1'b1;
               if (crossed) begin
                  noise_in = noise_stepped;
               end
            end
            REQ_CONTROL: begin
               volume_in = control_byte[2:0];
               boom_in   = control_byte[3];
               low_in    = control_byte[4];
               high_in   = control_byte[5];
            end
            REQ_NOISE_CLEAR: begin
               noise_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign tick_entry.target    = target_tick;
   assign tick_entry.steps     = steps;
   assign tick_entry.pos       = cur[SINE_IDX_W+1:1];
   assign tick_entry.tone_low  = low_ff;
   assign tick_entry.tone_high = high_ff;
   assign tick_entry.explosion = boom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= STEP_RESET_VALUE;
         phase_ff  <= '0;
         last_ff   <= '0;
         noise_ff  <= '0;
         target_ff <= '0;
         volume_ff <= '0;
         low_ff    <= 1'b0;
         high_ff   <= 1'b0;
         boom_ff   <= 1'b0;
      end else begin
         step_ff   <= step_in;
         phase_ff  <= phase_in;
         last_ff   <= last_in;
         noise_ff  <= noise_in;
         target_ff <= target_in;
         volume_ff <= volume_in;
         low_ff    <= low_in;
         high_ff   <= high_in;
         boom_ff   <= boom_in;
      end
   end

endmodule

// File: hw/rtl/nts_back.sv
`include "assert_macros.svh"

module nts_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  nts_pkg::tick_entry_type           q_data,
   output logic                              q_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic signed [nts_pkg::SAMPLE_W-1:0] sample
);
   import nts_pkg::*;

   back_state_type        state_ff, state_in;
   tick_entry_type        entry_ff, entry_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SMOOTH_W-1:0]   smooth_ff, smooth_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]   out_ff, out_in;

   logic                  out_free;
   logic signed [SMOOTH_W:0] delta;
   logic [SMOOTH_W:0]     smooth_next;
   logic [SUM_W-1:0]      sum;
   logic [SUM_W-1:0]      tone_lo, tone_hi, boom;

   assign out_free = !out_valid_ff || pop;
   assign empty    = !out_valid_ff;
   assign sample   = out_ff;

   assign delta       = $signed({1'b0, entry_ff.target, 16'b0}) - $signed({1'b0, smooth_ff});
   assign smooth_next = {1'b0, smooth_ff} + (SMOOTH_W+1)'(delta >>> 7);

   assign tone_lo = entry_ff.tone_low ?
                    SUM_W'(wave_lookup(entry_ff.pos[SINE_IDX_W:1])) : '0;
   assign tone_hi = entry_ff.tone_high ?
                    SUM_W'(wave_lookup(entry_ff.pos[SINE_IDX_W-1:0])) : '0;
   assign boom    = entry_ff.explosion ? SUM_W'(smooth_ff[SMOOTH_W-1:14]) : '0;
   assign sum     = SUM_W'({smooth_ff[SMOOTH_W-1:16], 1'b0}) + tone_lo + tone_hi + boom;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = (q_data.steps != '0) ? BK_SMOOTH : BK_MIX;
            end
         end
         BK_SMOOTH: begin
            if (cnt_ff == STEP_CNT_W'(1)) begin
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      entry_in     = entry_ff;
      cnt_in       = cnt_ff;
      smooth_in    = smooth_ff;
      out_valid_in = out_valid_ff && !pop;
      out_in       = out_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_data;
               cnt_in   = q_data.steps;
            end
         end
         BK_SMOOTH: begin
            smooth_in = smooth_next[SMOOTH_W-1:0];
            cnt_in    = cnt_ff - 1'b1;
         end
         BK_MIX: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = {sum, 5'b0} - SAMPLE_OFFSET;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         smooth_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         smooth_ff    <= smooth_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      out_ff   <= out_in;
   end

   `ASSERT_HOLDS(a_smooth_range, smooth_ff <= SMOOTH_MAX, "smoothed noise out of range")
   `ASSERT_IMPLIES(a_smooth_count, state_ff == BK_SMOOTH, cnt_ff != '0, "smoothing with zero count")
   `ASSERT_NEXT(a_pop_starts_work, q_pop, state_ff != BK_IDLE, "queue entry taken but no work")

endmodule

// File: hw/rtl/noise_tone_sound_synth_core.sv
// Noise and tone sound synthesizer core.
// Request channel (push/full): req_type selects a sample tick, a control byte
// write (req_control_byte: volume, explosion, two tone enables) or a noise
// shift register clear. A transaction completes when push is high and full low.
// Response channel (empty/pop): one signed sample, rsp_audio_sample, per tick;
// the oldest sample is shown while empty is low and leaves when pop is high.
// CSR channel (valid/ready): csr_oversample_step, taken whenever valid is high.
// The front end acts on every accepted request and queues ticks four deep.
// The back end takes one tick from the queue when idle, steps the noise
// smoother once per oversample step of that tick, capped at 128 and skipped
// when there are none, then mixes the sample; it takes the next tick only once
// that sample has gone into the output register. A tick holds about 17
// oversample steps at the reset step value.
// When pop is held low the finished sample waits in the output register, the
// back end stops in its mix cycle and the queue fills until full rises.
// Reset is synchronous: control state clears but the data registers do not,
// and the step register returns to its default of 768000 / 44100 in 16.16.
module noise_tone_sound_synth_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic [1:0]                           req_type,
   input  logic [7:0]                           req_control_byte,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [nts_pkg::SAMPLE_W-1:0]  rsp_audio_sample,
   input  logic                                 valid,
   output logic                                 ready,
   input  logic [nts_pkg::STEP_REG_W-1:0]       csr_oversample_step
);
   import nts_pkg::*;

   logic           accept;
   logic           tick_push;
   tick_entry_type tick_entry;
   tick_entry_type q_data;
   logic           q_empty;
   logic           q_pop;

   assign ready  = 1'b1;
   assign accept = push && !full;

   nts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .kind         (req_type),
      .control_byte (req_control_byte),
      .step_wr      (valid),
      .step_data    (csr_oversample_step),
      .tick_push    (tick_push),
      .tick_entry   (tick_entry)
   );

   nts_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tick_push),
      .wr_data (tick_entry),
      .full    (full),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .empty   (q_empty)
   );

   nts_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .sample  (rsp_audio_sample)
   );

endmodule
